// ===== rtl/core/hsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants of the high-side switch current diagnostic core.
// ----------------------------------------------------------------------------
package hsd_pkg;

   // ADC sample format and full scale of the current-sense converter.
   localparam int ADC_W          = 12;
   localparam int ADC_MAX        = 4095;
   localparam int ADC_FULL_SCALE = 4096;
   localparam int FS_LOG         = 12;

   // Milliamp scaling: mean * 10000 / full scale, saturated at 9999.
   localparam int MA_SCALE_W = 14;
   localparam int MA_W       = 14;
   localparam logic [MA_SCALE_W-1:0] MA_SCALE = MA_SCALE_W'(10000);
   localparam logic [MA_W-1:0]       MA_MAX   = MA_W'(9999);

   // Limit register widths.
   localparam int LIMIT_W = 12;
   localparam int OPEN_W  = 14;

   // Configuration port format.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   // Sense mux selection codes.
   localparam logic [1:0] MUX_HIGHZ = 2'd0;
   localparam logic [1:0] MUX_CH0   = 2'd1;
   localparam logic [1:0] MUX_CH1   = 2'd2;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_GROUND_LIMIT    = 3'd0,
      CSR_OVERCURRENT_LIMIT_CH0 = 3'd1,
      CSR_OVERCURRENT_LIMIT_CH1 = 3'd2,
      CSR_OPEN_LIMIT_CH0        = 3'd3,
      CSR_OPEN_LIMIT_CH1        = 3'd4,
      CSR_OPEN_CHECK_OFF_CH1    = 3'd5
   } csr_index_type;

   // Current register contents, handed to the classifier.
   typedef struct packed {
      logic [LIMIT_W-1:0] short_ground_limit;
      logic [LIMIT_W-1:0] overcurrent_limit_ch0;
      logic [LIMIT_W-1:0] overcurrent_limit_ch1;
      logic [OPEN_W-1:0]  open_limit_ch0;
      logic [OPEN_W-1:0]  open_limit_ch1;
      logic               open_check_off_ch1;
   } csr_type;

   // Control fields that travel with a transaction down the pipeline.
   typedef struct packed {
      logic [1:0] mux_code;
      logic       result_ready;
      logic       result_channel;
   } stage_ctrl_type;

endpackage

// ===== rtl/core/hsd_csr.sv =====
// ----------------------------------------------------------------------------
// hsd_csr
// Configuration registers: limits and the channel 1 open-load disable.
// ----------------------------------------------------------------------------
module hsd_csr
   import hsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_type               csr
);

   csr_type csr_ff;
   csr_type csr_in;

   // Decode the register index; writes beyond the list are dropped.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SHORT_GROUND_LIMIT:    csr_in.short_ground_limit    = csr_wdata[LIMIT_W-1:0];
            CSR_OVERCURRENT_LIMIT_CH0: csr_in.overcurrent_limit_ch0 = csr_wdata[LIMIT_W-1:0];
            CSR_OVERCURRENT_LIMIT_CH1: csr_in.overcurrent_limit_ch1 = csr_wdata[LIMIT_W-1:0];
            CSR_OPEN_LIMIT_CH0:        csr_in.open_limit_ch0        = csr_wdata[OPEN_W-1:0];
            CSR_OPEN_LIMIT_CH1:        csr_in.open_limit_ch1        = csr_wdata[OPEN_W-1:0];
            CSR_OPEN_CHECK_OFF_CH1:    csr_in.open_check_off_ch1    = csr_wdata[0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.short_ground_limit    <= LIMIT_W'(3276);
         csr_ff.overcurrent_limit_ch0 <= LIMIT_W'(410);
         csr_ff.overcurrent_limit_ch1 <= LIMIT_W'(1025);
         csr_ff.open_limit_ch0        <= OPEN_W'(1);
         csr_ff.open_limit_ch1        <= OPEN_W'(50);
         csr_ff.open_check_off_ch1    <= 1'b0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== rtl/core/hsd_seq.sv =====
// ----------------------------------------------------------------------------
// hsd_seq
// Channel sequencer and sample accumulator; forms the trimmed sum of a
// completed measurement and registers it for the divide stage.
// ----------------------------------------------------------------------------
module hsd_seq
   import hsd_pkg::*;
#(
   parameter  int SAMPLES_PER_MEAN = 5,
   localparam int SUM_W = $clog2(SAMPLES_PER_MEAN * ADC_MAX + 1),
   localparam int CNT_W = $clog2(SAMPLES_PER_MEAN)
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_ch0_on,
   input  logic             req_ch1_on,
   input  logic             req_sample_valid,
   input  logic [ADC_W-1:0] req_adc_sample,
   output logic             out_valid,
   input  logic             out_ready,
   output stage_ctrl_type   out_ctrl,
   output logic [SUM_W-1:0] out_trimmed
);

   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_MEAN - 1);

   typedef enum logic [1:0] {
      PH_SETUP  = 2'b01,
      PH_SAMPLE = 2'b10
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic             chan_ff, chan_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [ADC_W-1:0] max_ff, max_in;
   logic [ADC_W-1:0] min_ff, min_in;
   logic [1:0]       mux_ff, mux_in;

   logic             a_valid_ff;
   stage_ctrl_type   a_ctrl_ff;
   logic [SUM_W-1:0] a_trimmed_ff;

   logic             fire;
   logic             chan_on;
   logic             done;
   logic [SUM_W-1:0] upd_sum;
   logic [ADC_W-1:0] upd_max;
   logic [ADC_W-1:0] upd_min;
   logic [SUM_W-1:0] trimmed;

   // Output register frees up when it is empty or drained this cycle.
   assign req_ready = !a_valid_ff || out_ready;
   assign fire      = req_valid && req_ready;

   // Running sum, maximum and minimum including the incoming sample.
   assign chan_on = chan_ff ? req_ch1_on : req_ch0_on;
   assign upd_sum = sum_ff + SUM_W'(req_adc_sample);
   assign upd_max = (req_adc_sample > max_ff) ? req_adc_sample : max_ff;
   assign upd_min = (req_adc_sample < min_ff) ? req_adc_sample : min_ff;
   assign trimmed = upd_sum - SUM_W'(upd_max) - SUM_W'(upd_min);

   // Sequencer: mux setup, then sampling until the mean is complete.
   always_comb begin
      phase_in = phase_ff;
      chan_in  = chan_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      mux_in   = mux_ff;
      done     = 1'b0;
      unique case (phase_ff)
         PH_SETUP: begin
            if (chan_on) begin
               mux_in   = chan_ff ? MUX_CH1 : MUX_CH0;
               phase_in = PH_SAMPLE;
               count_in = '0;
               sum_in   = '0;
               max_in   = '0;
               min_in   = ADC_W'(ADC_MAX);
            end else begin
               chan_in = ~chan_ff;
            end
         end
         PH_SAMPLE: begin
            if (req_sample_valid) begin
               if (count_ff == LAST_COUNT) begin
                  done     = 1'b1;
                  chan_in  = ~chan_ff;
                  phase_in = PH_SETUP;
                  count_in = '0;
                  sum_in   = '0;
                  max_in   = '0;
                  min_in   = ADC_W'(ADC_MAX);
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = upd_sum;
                  max_in   = upd_max;
                  min_in   = upd_min;
               end
            end
         end
         default: phase_in = PH_SETUP;
      endcase
   end

   // Sequencer state advances once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SETUP;
         chan_ff  <= 1'b0;
         count_ff <= '0;
         sum_ff   <= '0;
         max_ff   <= '0;
         min_ff   <= ADC_W'(ADC_MAX);
         mux_ff   <= MUX_HIGHZ;
      end else if (fire) begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         mux_ff   <= mux_in;
      end
   end

   // Stage register toward the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (fire) begin
         a_valid_ff <= 1'b1;
      end else if (out_ready) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         a_ctrl_ff.mux_code       <= mux_in;
         a_ctrl_ff.result_ready   <= done;
         a_ctrl_ff.result_channel <= done & chan_ff;
         a_trimmed_ff             <= done ? trimmed : '0;
      end
   end

   assign out_valid   = a_valid_ff;
   assign out_ctrl    = a_ctrl_ff;
   assign out_trimmed = a_trimmed_ff;

`ifndef ASSERT_OFF
   // The sample count never reaches the mean length: it wraps on completion.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_COUNT)
      else $error("sample count beyond mean length");

   // A completed measurement always returns the sequencer to mux setup.
   a_done_to_setup: assert property (@(posedge clock) disable iff (reset)
      (fire && done) |=> (phase_ff == PH_SETUP))
      else $error("sequencer did not return to setup");

   // While sampling, the mux holds the selection of the active channel.
   a_mux_matches: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SAMPLE) |-> (mux_ff == (chan_ff ? MUX_CH1 : MUX_CH0)))
      else $error("mux selection does not match active channel");

   // Once a sample is in, the running minimum cannot exceed the maximum.
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SAMPLE && count_ff != '0) |-> (min_ff <= max_ff))
      else $error("running minimum above maximum");
`endif

endmodule

// ===== rtl/core/hsd_mean.sv =====
// ----------------------------------------------------------------------------
// hsd_mean
// Divides the trimmed sum by the number of kept samples with a constant
// reciprocal multiply and registers the mean code.
// ----------------------------------------------------------------------------
module hsd_mean
   import hsd_pkg::*;
#(
   parameter  int SAMPLES_PER_MEAN = 5,
   localparam int SUM_W = $clog2(SAMPLES_PER_MEAN * ADC_MAX + 1)
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  stage_ctrl_type   in_ctrl,
   input  logic [SUM_W-1:0] in_trimmed,
   output logic             out_valid,
   input  logic             out_ready,
   output stage_ctrl_type   out_ctrl,
   output logic [ADC_W-1:0] out_mean
);

   // Exact floor division for any dividend below 2**SUM_W:
   // q = (t * ceil(2**(SUM_W+L) / D)) >> (SUM_W+L), L = ceil(log2 D).
   localparam int DIVISOR = SAMPLES_PER_MEAN - 2;
   localparam int DIV_LOG = $clog2(DIVISOR);
   localparam int SHIFT   = SUM_W + DIV_LOG;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int RECIP   = ((1 << SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

   logic             b_valid_ff;
   stage_ctrl_type   b_ctrl_ff;
   logic [ADC_W-1:0] b_mean_ff;

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] quot;
   logic [ADC_W-1:0]  mean;
   logic              fire;

   assign in_ready = !b_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // Reciprocal multiply, then clamp to the ADC code range.
   assign prod = PROD_W'(in_trimmed) * PROD_W'(RECIP_C);
   assign quot = prod >> SHIFT;
   assign mean = (quot > PROD_W'(ADC_MAX)) ? ADC_W'(ADC_MAX) : quot[ADC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (fire) begin
         b_valid_ff <= 1'b1;
      end else if (out_ready) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         b_ctrl_ff <= in_ctrl;
         b_mean_ff <= mean;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_ctrl  = b_ctrl_ff;
   assign out_mean  = b_mean_ff;

endmodule

// ===== rtl/core/hsd_scale.sv =====
// ----------------------------------------------------------------------------
// hsd_scale
// Scales the mean code to milliamps, classifies the fault and holds the
// response transaction in the output register.
// ----------------------------------------------------------------------------
module hsd_scale
   import hsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  csr_type          csr,
   input  logic             in_valid,
   output logic             in_ready,
   input  stage_ctrl_type   in_ctrl,
   input  logic [ADC_W-1:0] in_mean,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_mux_code,
   output logic             rsp_result_ready,
   output logic             rsp_result_channel,
   output logic [ADC_W-1:0] rsp_mean_code,
   output logic [MA_W-1:0]  rsp_current_ma,
   output logic             rsp_short_to_ground,
   output logic             rsp_over_current,
   output logic             rsp_open_load
);

   localparam int PROD_W = ADC_W + MA_SCALE_W;

   logic             c_valid_ff;
   stage_ctrl_type   c_ctrl_ff;
   logic [ADC_W-1:0] c_mean_ff;
   logic [MA_W-1:0]  c_ma_ff;
   logic             c_s2g_ff;
   logic             c_oc_ff;
   logic             c_open_ff;

   logic [PROD_W-1:0]  ma_prod;
   logic [MA_W-1:0]    ma_full;
   logic [MA_W-1:0]    ma;
   logic [LIMIT_W-1:0] oc_limit;
   logic               s2g;
   logic               oc;
   logic               open;
   logic               fire;

   assign in_ready = !c_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   // Milliamps: mean * 10000 / full scale, full scale being a power of two.
   assign ma_prod = PROD_W'(in_mean) * PROD_W'(MA_SCALE);
   assign ma_full = ma_prod[FS_LOG +: MA_W];
   assign ma      = (ma_full > MA_MAX) ? MA_MAX : ma_full;

   // Fault classification in priority order: short, over-current, open load.
   assign oc_limit = in_ctrl.result_channel ? csr.overcurrent_limit_ch1
                                            : csr.overcurrent_limit_ch0;
   always_comb begin
      s2g  = 1'b0;
      oc   = 1'b0;
      open = 1'b0;
      priority if (in_mean > csr.short_ground_limit) begin
         s2g = 1'b1;
      end else if (in_mean > oc_limit) begin
         oc = 1'b1;
      end else if (!in_ctrl.result_channel) begin
         open = csr.open_limit_ch0 > ma;
      end else begin
         open = !csr.open_check_off_ch1 && (csr.open_limit_ch1 > ma);
      end
   end

   // Output register; result fields read zero when nothing completed.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (fire) begin
         c_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         c_ctrl_ff <= in_ctrl;
         c_mean_ff <= in_ctrl.result_ready ? in_mean : '0;
         c_ma_ff   <= in_ctrl.result_ready ? ma : '0;
         c_s2g_ff  <= in_ctrl.result_ready & s2g;
         c_oc_ff   <= in_ctrl.result_ready & oc;
         c_open_ff <= in_ctrl.result_ready & open;
      end
   end

   assign rsp_valid           = c_valid_ff;
   assign rsp_mux_code        = c_ctrl_ff.mux_code;
   assign rsp_result_ready    = c_ctrl_ff.result_ready;
   assign rsp_result_channel  = c_ctrl_ff.result_channel;
   assign rsp_mean_code       = c_mean_ff;
   assign rsp_current_ma      = c_ma_ff;
   assign rsp_short_to_ground = c_s2g_ff;
   assign rsp_over_current    = c_oc_ff;
   assign rsp_open_load       = c_open_ff;

endmodule

// ===== rtl/core/high_side_switch_current_diag_core.sv =====
// ----------------------------------------------------------------------------
// high_side_switch_current_diag_core
// Current-sense diagnostic sequencer for two high-side channels sharing one
// sense pin: trimmed mean, milliamp scaling and fault classification.
// ----------------------------------------------------------------------------
// Each request transaction is one tick and produces exactly one response
// transaction. The core accepts one transaction per clock cycle unless a
// stalled response has filled all stages, and returns its response through
// three register stages: the sequencer and accumulator, the reciprocal-
// multiply divide by the number of kept samples, and the milliamp scaling
// with fault classification. The sequencer state updates once per tick.
// A stalled response holds its stage; the earlier stages keep accepting
// until all three are full. Limit registers may only be written while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module high_side_switch_current_diag_core
   import hsd_pkg::*;
#(
   parameter int SAMPLES_PER_MEAN = 5
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_ch0_on,
   input  logic                  req_ch1_on,
   input  logic                  req_sample_valid,
   input  logic [ADC_W-1:0]      req_adc_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_mux_code,
   output logic                  rsp_result_ready,
   output logic                  rsp_result_channel,
   output logic [ADC_W-1:0]      rsp_mean_code,
   output logic [MA_W-1:0]       rsp_current_ma,
   output logic                  rsp_short_to_ground,
   output logic                  rsp_over_current,
   output logic                  rsp_open_load
);

   localparam int SUM_W = $clog2(SAMPLES_PER_MEAN * ADC_MAX + 1);

   csr_type          csr;
   logic             a_valid;
   logic             a_ready;
   stage_ctrl_type   a_ctrl;
   logic [SUM_W-1:0] a_trimmed;
   logic             b_valid;
   logic             b_ready;
   stage_ctrl_type   b_ctrl;
   logic [ADC_W-1:0] b_mean;

   // Configuration registers.
   hsd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .csr          (csr)
   );

   // Channel sequencer and accumulator.
   hsd_seq #(
      .SAMPLES_PER_MEAN (SAMPLES_PER_MEAN)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch0_on       (req_ch0_on),
      .req_ch1_on       (req_ch1_on),
      .req_sample_valid (req_sample_valid),
      .req_adc_sample   (req_adc_sample),
      .out_valid        (a_valid),
      .out_ready        (a_ready),
      .out_ctrl         (a_ctrl),
      .out_trimmed      (a_trimmed)
   );

   // Trimmed-mean divide.
   hsd_mean #(
      .SAMPLES_PER_MEAN (SAMPLES_PER_MEAN)
   ) u_mean (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (a_valid),
      .in_ready   (a_ready),
      .in_ctrl    (a_ctrl),
      .in_trimmed (a_trimmed),
      .out_valid  (b_valid),
      .out_ready  (b_ready),
      .out_ctrl   (b_ctrl),
      .out_mean   (b_mean)
   );

   // Milliamp scaling, classification and response register.
   hsd_scale u_scale (
      .clock               (clock),
      .reset               (reset),
      .csr                 (csr),
      .in_valid            (b_valid),
      .in_ready            (b_ready),
      .in_ctrl             (b_ctrl),
      .in_mean             (b_mean),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mux_code        (rsp_mux_code),
      .rsp_result_ready    (rsp_result_ready),
      .rsp_result_channel  (rsp_result_channel),
      .rsp_mean_code       (rsp_mean_code),
      .rsp_current_ma      (rsp_current_ma),
      .rsp_short_to_ground (rsp_short_to_ground),
      .rsp_over_current    (rsp_over_current),
      .rsp_open_load       (rsp_open_load)
   );

endmodule
